FILE: design/cwg_pkg.sv
// shared types and constants for the coincidence window grouper
// request structs, slot store word, drain job, register codes
// no dependencies
package cwg_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W       = CH_W + 1;          // bank bit above channel
  localparam int RAM_DEPTH    = 2 ** ADDR_W;

  localparam int TIME_W   = 63;
  localparam int ENERGY_W = 16;
  localparam int FLAGS_W  = 32;
  localparam int WIN_W    = 31;
  localparam int GROUP_W  = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [WIN_W-1:0] WINDOW_LO_RESET = -31'sd300000;
  localparam logic signed [WIN_W-1:0] WINDOW_HI_RESET = 31'sd300000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LO = 1'b0,
    REG_WINDOW_HI = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [5:0]          hit_channel;
    logic [TIME_W-1:0]   hit_time_ps;
    logic [ENERGY_W-1:0] hit_energy;
    logic [FLAGS_W-1:0]  hit_flags;
    logic                end_of_data;
  } hit_req_t;

  typedef struct packed {
    logic [GROUP_W-1:0]  group_number;
    logic [5:0]          slot_channel;
    logic [TIME_W-1:0]   slot_time_ps;
    logic [ENERGY_W-1:0] slot_energy;
    logic [FLAGS_W-1:0]  slot_flags;
    logic                last_of_group;
  } slot_req_t;

  typedef struct packed {
    logic [TIME_W-1:0]   time_ps;
    logic [ENERGY_W-1:0] energy;
    logic [FLAGS_W-1:0]  flags;
  } slot_word_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    slot_word_t        data;
  } ram_wr_t;

  typedef struct packed {
    logic                    valid;
    logic                    bank;
    logic [NUM_CHANNELS-1:0] mask;
    logic [GROUP_W-1:0]      group_number;
  } drain_job_t;

endpackage

FILE: design/cwg_slot_ram.sv
// double-buffered slot store: two banks of per-channel slot words
// one write port, one read port with registered read data
// depends on cwg_pkg
module cwg_slot_ram (
  input  logic                   clk,
  input  cwg_pkg::ram_wr_t       wr,
  input  logic                   rd_en,
  input  logic [cwg_pkg::ADDR_W-1:0] rd_addr,
  output cwg_pkg::slot_word_t    rd_data
);
  import cwg_pkg::*;

  slot_word_t mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/cwg_intake.sv
// hit intake: window registers, anchor, open group mask, slot writes
// hands closed groups to the drain side as a job
// depends on cwg_pkg
module cwg_intake (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwg_pkg::WIN_W-1:0]   cfg_data,
  input  logic                        hit_valid,
  output logic                        hit_ready,
  input  cwg_pkg::hit_req_t           hit,
  input  logic                        drain_free,
  output cwg_pkg::drain_job_t         job,
  output cwg_pkg::ram_wr_t            wr
);
  import cwg_pkg::*;

  localparam logic [6:0] NUM_CH_L = 7'(NUM_CHANNELS);

  logic [WIN_W-1:0]        window_lo;
  logic [WIN_W-1:0]        window_hi;
  logic                    group_open;
  logic [TIME_W-1:0]       anchor_time;
  logic [GROUP_W-1:0]      group_count;
  logic                    bank;
  logic [NUM_CHANNELS-1:0] mask;

  logic                    in_range;
  logic [CH_W-1:0]         ch_idx;
  logic [NUM_CHANNELS-1:0] ch_bit;
  logic signed [63:0]      dt;
  logic signed [63:0]      lo_ext;
  logic signed [63:0]      hi_ext;
  logic                    zero_in;
  logic                    joins;
  logic                    need_close;
  logic                    accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_lo <= WINDOW_LO_RESET;
      window_hi <= WINDOW_HI_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LO: window_lo <= cfg_data;
        REG_WINDOW_HI: window_hi <= cfg_data;
      endcase
    end
  end

  assign in_range = {1'b0, hit.hit_channel} < NUM_CH_L;
  assign ch_idx   = hit.hit_channel[CH_W-1:0];

  always_comb begin
    ch_bit = '0;
    if (in_range) begin
      ch_bit[ch_idx] = 1'b1;
    end
  end

  // exact signed difference, both times are nonnegative 63-bit values
  assign dt      = $signed({1'b0, hit.hit_time_ps}) - $signed({1'b0, anchor_time});
  assign lo_ext  = {{(64-WIN_W){window_lo[WIN_W-1]}}, window_lo};
  assign hi_ext  = {{(64-WIN_W){window_hi[WIN_W-1]}}, window_hi};
  assign zero_in = (window_lo[WIN_W-1] || window_lo == '0) && !window_hi[WIN_W-1];
  assign joins   = zero_in && (dt >= lo_ext) && (dt <= hi_ext);

  assign need_close = group_open && (hit.end_of_data || (in_range && !joins));
  assign hit_ready  = !need_close || drain_free;
  assign accept     = hit_valid && hit_ready;

  assign job.valid        = accept && need_close;
  assign job.bank         = bank;
  assign job.mask         = mask;
  assign job.group_number = group_count;

  always_comb begin
    wr.en        = accept && !hit.end_of_data && in_range;
    wr.addr      = {(need_close ? ~bank : bank), ch_idx};
    wr.data      = '{time_ps: hit.hit_time_ps, energy: hit.hit_energy, flags: hit.hit_flags};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_open  <= 1'b0;
      anchor_time <= '0;
      group_count <= '0;
      bank        <= 1'b0;
      mask        <= '0;
    end else if (accept) begin
      if (hit.end_of_data) begin
        if (group_open) begin
          group_open <= 1'b0;
          bank       <= ~bank;
          mask       <= '0;
        end
      end else if (in_range) begin
        if (group_open && joins) begin
          mask <= mask | ch_bit;
        end else begin
          // new anchor; a closing group moves to the other bank
          if (group_open) begin
            bank <= ~bank;
          end
          group_open  <= 1'b1;
          anchor_time <= hit.hit_time_ps;
          group_count <= group_count + 1'b1;
          mask        <= ch_bit;
        end
      end
    end
  end

endmodule

FILE: design/cwg_drain.sv
// drain side: walks a closed group's slots in ascending channel order,
// reads each slot word and presents it through an output register
// depends on cwg_pkg
module cwg_drain (
  input  logic                        clk,
  input  logic                        rst,
  input  cwg_pkg::drain_job_t         job,
  output logic                        drain_free,
  output logic                        rd_en,
  output logic [cwg_pkg::ADDR_W-1:0]  rd_addr,
  input  cwg_pkg::slot_word_t         rd_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output cwg_pkg::slot_req_t          res
);
  import cwg_pkg::*;

  logic [NUM_CHANNELS-1:0] mask;
  logic                    bank;
  logic [GROUP_W-1:0]      group_number;

  logic                    p1_valid;
  logic [CH_W-1:0]         p1_channel;
  logic                    p1_last;
  logic [GROUP_W-1:0]      p1_group;

  logic                    busy;
  logic [CH_W-1:0]         first_idx;
  logic [NUM_CHANNELS-1:0] first_bit;
  logic [NUM_CHANNELS-1:0] rest_mask;
  logic                    last;
  logic                    p1_adv;
  logic                    issue;

  assign busy = |mask;

  // lowest filled channel
  always_comb begin
    first_idx = '0;
    first_bit = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        first_idx = CH_W'(i);
      end
    end
    first_bit[first_idx] = busy;
  end

  assign rest_mask  = mask & ~first_bit;
  assign last       = rest_mask == '0;
  assign p1_adv     = p1_valid && (!res_valid || res_ready);
  assign issue      = busy && (!p1_valid || p1_adv);
  assign drain_free = !busy || (issue && last);

  assign rd_en   = issue;
  assign rd_addr = {bank, first_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (job.valid) begin
      mask <= job.mask;
    end else if (issue) begin
      mask <= rest_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (job.valid) begin
      bank         <= job.bank;
      group_number <= job.group_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (issue) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_channel <= first_idx;
      p1_last    <= last;
      p1_group   <= group_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (p1_adv) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      res.group_number  <= p1_group;
      res.slot_channel  <= 6'(p1_channel);
      res.slot_time_ps  <= rd_data.time_ps;
      res.slot_energy   <= rd_data.energy;
      res.slot_flags    <= rd_data.flags;
      res.last_of_group <= p1_last;
    end
  end

endmodule

FILE: design/coincidence_window_grouper_unit.sv
// top level of the coincidence window grouper
// intake, double-buffered slot store and drain side
// depends on cwg_pkg, cwg_intake, cwg_slot_ram, cwg_drain
//
// Groups time-ordered detector hits into coincidence groups. The first hit of
// a group is its anchor; a later hit joins while window_lo <= t - anchor <=
// window_hi (and 0 lies in the window), overwriting the slot of a channel that
// is already present. The first hit that fails closes the group and anchors a
// new one; an end-of-data request flushes the open group. A closed group comes
// out as one response request per filled channel, ascending channel order,
// with last_of_group on the final one. Hits on channels >= NUM_CHANNELS are
// dropped. Intake takes one hit request per clock. Slots live in a two-bank
// memory: the open group fills one bank while the previous group drains from
// the other at one slot per clock through the single read port, so the only
// intake stall is a group close while the previous group still has slots not
// yet read (each slot needs its own read, and output backpressure can hold
// the drain). Window registers must be written through cfg_we / cfg_index /
// cfg_data (index 0 lower bound, index 1 upper bound, 31-bit signed
// picoseconds) only while the block is idle; the block does not enforce it.

module coincidence_window_grouper_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [cwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwg_pkg::WIN_W-1:0]     cfg_data,
  // hit requests
  input  logic                          hit_valid,
  output logic                          hit_ready,
  input  cwg_pkg::hit_req_t             hit,
  // slot responses
  output logic                          res_valid,
  input  logic                          res_ready,
  output cwg_pkg::slot_req_t            res
);
  import cwg_pkg::*;

  drain_job_t          job;         // closed group handed to the drain side
  logic                drain_free;  // drain can take a job this cycle
  ram_wr_t             wr;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  slot_word_t          rd_data;

  // intake: window check against the anchor, slot writes into the open bank
  cwg_intake u_intake (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .hit_valid  (hit_valid),
    .hit_ready  (hit_ready),
    .hit        (hit),
    .drain_free (drain_free),
    .job        (job),
    .wr         (wr)
  );

  // slot store, bank bit selects the open or the draining group
  cwg_slot_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // drain: one slot read per clock unless output backpressure stalls it, registered response
  cwg_drain u_drain (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .drain_free (drain_free),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule
